// ===== rtl/smp_pkg.sv =====
// Package for the SHA message padder: controller states, word generator
// selects and the command and status groups between controller and datapath.
// No dependencies.
package smp_pkg;

	// Byte constants of the padding scheme.
	localparam logic [7:0] PadMarker   = 8'h80;
	localparam logic [5:0] LongTailMin = 6'd56;
	localparam logic [3:0] LastWord    = 4'd15;
	localparam logic [3:0] LenHiWord   = 4'd14;
	localparam logic [3:0] LenLoWord   = 4'd15;
	localparam logic [63:0] BitsPerByte = 64'd8;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DATA,
		ST_PAD,
		ST_ZLEN
	} state_t;

	// What the word generator builds.
	typedef enum logic [1:0] {
		GEN_DATA,
		GEN_PAD,
		GEN_ZLEN
	} gen_sel_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic     wr_byte;
		logic     emit;
		gen_sel_t gen_sel;
		logic     with_len;
		logic     final_blk;
		logic     last_run;
		logic     clear_msg;
	} ctrl_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic fill_full;
		logic long_tail;
		logic word_last;
		logic slot_free;
	} dp_status_t;

endpackage

// ===== rtl/smp_datapath.sv =====
// Datapath of the SHA message padder: block buffer, byte and bit counts,
// word generator and output register.
// Depends on smp_pkg.
module smp_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  smp_pkg::ctrl_cmd_t cmd,
	output smp_pkg::dp_status_t status,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        block_word,
	output logic [3:0]         word_index,
	output logic               final_block,
	output logic               last_of_run
);

	logic [31:0] buf_q [16];
	logic [5:0]  fill_q;
	logic [63:0] total_q;
	logic [3:0]  cnt_q;
	logic        out_valid_q;
	logic [31:0] word_q;
	logic [3:0]  index_q;
	logic        final_q;
	logic        last_q;
	logic [31:0] raw_word;
	logic [31:0] gen_word;

	// Block buffer, written one byte at a time, first byte in the top bits.
	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= data_byte;
		end
	end

	// Pending byte count and message bit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
		end else if (cmd.clear_msg) begin
			fill_q  <= '0;
			total_q <= '0;
		end else if (cmd.wr_byte) begin
			fill_q  <= fill_q + 6'd1;
			total_q <= total_q + smp_pkg::BitsPerByte;
		end
	end

	// Word counter within the block being emitted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.emit) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	// Word generator: data gives the buffer; pad gives bytes below the fill
	// count, marker at it, zeros past; else 0; bit count last two if with_len.
	assign raw_word = buf_q[cnt_q];

	always_comb begin
		logic [5:0] idx;
		gen_word = '0;
		for (int j = 0; j < 4; j++) begin
			idx = {cnt_q, 2'(j)};
			case (cmd.gen_sel)
				smp_pkg::GEN_DATA: begin
					gen_word[(3 - j) * 8 +: 8] = raw_word[(3 - j) * 8 +: 8];
				end
				smp_pkg::GEN_PAD: begin
					if (idx < fill_q) begin
						gen_word[(3 - j) * 8 +: 8] = raw_word[(3 - j) * 8 +: 8];
					end else if (idx == fill_q) begin
						gen_word[(3 - j) * 8 +: 8] = smp_pkg::PadMarker;
					end else begin
						gen_word[(3 - j) * 8 +: 8] = 8'h00;
					end
				end
				default: begin
					gen_word[(3 - j) * 8 +: 8] = 8'h00;
				end
			endcase
		end
		if (cmd.with_len && cnt_q == smp_pkg::LenHiWord) begin
			gen_word = total_q[63:32];
		end else if (cmd.with_len && cnt_q == smp_pkg::LenLoWord) begin
			gen_word = total_q[31:0];
		end
	end

	// Output register: control flag with reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			word_q  <= gen_word;
			index_q <= cnt_q;
			final_q <= cmd.final_blk;
			last_q  <= cmd.last_run && (cnt_q == smp_pkg::LastWord);
		end
	end

	// Status back to the controller.
	assign status.fill_full = (fill_q == 6'd63);
	assign status.long_tail = (fill_q >= smp_pkg::LongTailMin);
	assign status.word_last = (cnt_q == smp_pkg::LastWord);
	assign status.slot_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign block_word  = word_q;
	assign word_index  = index_q;
	assign final_block = final_q;
	assign last_of_run = last_q;

endmodule

// ===== rtl/smp_ctrl.sv =====
// Controller of the SHA message padder: takes items and sequences the
// data, padding and length-only blocks.
// Depends on smp_pkg.
module smp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                has_byte,
	input  logic                end_of_message,
	input  smp_pkg::dp_status_t status,
	output smp_pkg::ctrl_cmd_t  cmd
);

	smp_pkg::state_t state_q;
	smp_pkg::state_t state_d;
	logic            eom_q;
	logic            eom_d;
	logic            accept;

	// State register and the close flag held over a full data block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smp_pkg::ST_IDLE;
			eom_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			eom_q   <= eom_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		eom_d         = eom_q;
		cmd           = '0;
		cmd.gen_sel   = smp_pkg::GEN_DATA;
		in_stall      = 1'b1;
		accept        = 1'b0;
		case (state_q)
			smp_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				accept      = in_valid;
				cmd.wr_byte = accept && has_byte;
				if (accept && has_byte && status.fill_full) begin
					state_d = smp_pkg::ST_DATA;
					eom_d   = end_of_message;
				end else if (accept && end_of_message) begin
					state_d = smp_pkg::ST_PAD;
				end
			end
			smp_pkg::ST_DATA: begin
				cmd.emit     = status.slot_free;
				cmd.gen_sel  = smp_pkg::GEN_DATA;
				cmd.last_run = !eom_q;
				if (cmd.emit && status.word_last) begin
					state_d = eom_q ? smp_pkg::ST_PAD : smp_pkg::ST_IDLE;
				end
			end
			smp_pkg::ST_PAD: begin
				cmd.emit      = status.slot_free;
				cmd.gen_sel   = smp_pkg::GEN_PAD;
				cmd.with_len  = !status.long_tail;
				cmd.final_blk = !status.long_tail;
				cmd.last_run  = !status.long_tail;
				if (cmd.emit && status.word_last) begin
					cmd.clear_msg = !status.long_tail;
					state_d = status.long_tail ? smp_pkg::ST_ZLEN : smp_pkg::ST_IDLE;
				end
			end
			smp_pkg::ST_ZLEN: begin
				cmd.emit      = status.slot_free;
				cmd.gen_sel   = smp_pkg::GEN_ZLEN;
				cmd.with_len  = 1'b1;
				cmd.final_blk = 1'b1;
				cmd.last_run  = 1'b1;
				if (cmd.emit && status.word_last) begin
					cmd.clear_msg = 1'b1;
					state_d       = smp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = smp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/sha_message_padder.sv =====
// SHA message padder: packs a byte stream into 512-bit blocks of sixteen
// big-endian words, with 0x80 marker, zero fill and 64-bit bit count.
// Items are taken while idle; in_stall holds them off while a block is
// emitted. Words go out one per cycle through the output register while
// out_stall allows. Reset clears counts; buffer is not cleared.
module sha_message_padder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] block_word,
	output logic [3:0]  word_index,
	output logic        final_block,
	output logic        last_of_run
);

	smp_pkg::ctrl_cmd_t  cmd;
	smp_pkg::dp_status_t status;

	// Controller.
	smp_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.status         (status),
		.cmd            (cmd)
	);

	// Datapath.
	smp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.block_word  (block_word),
		.word_index  (word_index),
		.final_block (final_block),
		.last_of_run (last_of_run)
	);

endmodule
